// ----- design/gisu_pkg.sv -----
package gisu_pkg;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_VALUE_SOURCE   = 2'd0;
  localparam logic [1:0] REG_NULL_SOURCE    = 2'd1;
  localparam logic [1:0] REG_CONSTANT_VALUE = 2'd2;
  localparam logic [1:0] REG_CONSTANT_NULL  = 2'd3;

  // Value source codes (the unused code falls back to the row value)
  localparam logic [1:0] VS_ROW   = 2'd0;
  localparam logic [1:0] VS_CONST = 2'd1;
  localparam logic [1:0] VS_DICT  = 2'd2;

  // Null source codes
  localparam logic [1:0] NS_NEVER = 2'd0;
  localparam logic [1:0] NS_ROW   = 2'd1;
  localparam logic [1:0] NS_CONST = 2'd2;
  localparam logic [1:0] NS_DICT  = 2'd3;

  typedef struct packed {
    logic               op;
    logic [9:0]         group_index;
    logic signed [63:0] row_value;
    logic               row_null;
    logic [9:0]         dict_index;
    logic               batch_end;
  } item_t;

  typedef struct packed {
    logic [9:0]         group_out;
    logic signed [63:0] group_sum;
    logic               group_normal;
    logic               row_added;
    logic               batch_done;
  } result_t;

  // One word of the group memory
  typedef struct packed {
    logic        normal;
    logic [63:0] sum;
  } grp_entry_t;

  // One word of the dictionary memory
  typedef struct packed {
    logic        null_bit;
    logic [63:0] value;
  } dict_entry_t;

  // Reduce a 10-bit index modulo a constant by shifted compare and subtract.
  function automatic logic [9:0] idx_reduce(input logic [9:0] raw,
                                            input int unsigned modulus);
    logic [9:0]  rem;
    int unsigned step;
    rem = raw;
    for (int k = 8; k >= 0; k--) begin
      step = modulus << k;
      if (step <= 32'd1023 && 32'(rem) >= step) begin
        rem = rem - 10'(step);
      end
    end
    return rem;
  endfunction

endpackage

// ----- design/grouped_int64_sum_update.sv -----
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+---------------------------
// item      | in        | start && !busy               | item_i   (gisu_pkg::item_t)
// result    | out       | result_valid_o, one cycle    | result_o (gisu_pkg::result_t)
// config    | in        | cfg_we_i, no wait            | cfg_idx_i, cfg_data_i
//
// A load item writes its dictionary entry at the accept edge, and busy stays low.
// A row item issues the group and dictionary reads in the accept cycle; in the next cycle
// the block adds and writes the group entry back, and the result strobes in the cycle after
// that, while the next item may already be accepted. Busy stays high during the write-back,
// so the group read-modify-write holds off the next item. After reset the block sweeps the
// group memory to zero, one entry a cycle, with busy high. The result side cannot stall.
module grouped_int64_sum_update #(
  parameter int unsigned GROUP_COUNT = 1024,
  parameter int unsigned DICT_DEPTH  = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gisu_pkg::item_t   item_i,
  output logic              result_valid_o,
  output gisu_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i
);

  localparam int unsigned GW = $clog2(GROUP_COUNT);
  localparam int unsigned DW = $clog2(DICT_DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic [GW-1:0] clr_q;

  // Configuration registers
  logic [1:0]  value_source_q;
  logic [1:0]  null_source_q;
  logic [63:0] constant_value_q;
  logic        constant_null_q;

  // Row held during the execute cycle
  logic [GW-1:0] grp_q;
  logic [9:0]    grp_out_q;
  logic [63:0]   row_value_q;
  logic          row_null_q;
  logic          batch_q;

  // Memories and their registered read data
  gisu_pkg::grp_entry_t  grp_mem [GROUP_COUNT];
  gisu_pkg::dict_entry_t dict_mem [DICT_DEPTH];
  gisu_pkg::grp_entry_t  grp_rd_q;
  gisu_pkg::dict_entry_t dict_rd_q;

  logic                 accept;
  logic                 load_acc;
  logic                 row_acc;
  logic [9:0]           grp_red;
  logic [9:0]           dict_red;
  logic [GW-1:0]        grp_ra;
  logic [DW-1:0]        dict_a;
  logic [63:0]          add_val;
  logic                 is_null;
  gisu_pkg::grp_entry_t upd;
  logic                 grp_we;
  logic [GW-1:0]        grp_wa;
  gisu_pkg::grp_entry_t grp_wd;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign load_acc = accept && (item_i.op == gisu_pkg::OP_LOAD);
  assign row_acc  = accept && (item_i.op == gisu_pkg::OP_ROW);

  // Out-of-range indexes wrap onto the table depth
  assign grp_red  = gisu_pkg::idx_reduce(item_i.group_index, GROUP_COUNT);
  assign dict_red = gisu_pkg::idx_reduce(item_i.dict_index, DICT_DEPTH);
  assign grp_ra   = GW'(grp_red);
  assign dict_a   = DW'(dict_red);

  // Pick value and null flag for the row in the execute cycle
  always_comb begin
    case (value_source_q)
      gisu_pkg::VS_CONST: add_val = constant_value_q;
      gisu_pkg::VS_DICT:  add_val = dict_rd_q.value;
      default:            add_val = row_value_q;
    endcase
    case (null_source_q)
      gisu_pkg::NS_ROW:   is_null = row_null_q;
      gisu_pkg::NS_CONST: is_null = constant_null_q;
      gisu_pkg::NS_DICT:  is_null = dict_rd_q.null_bit;
      default:            is_null = 1'b0;
    endcase
  end

  // Updated entry; a null row leaves it as read
  always_comb begin
    upd = grp_rd_q;
    if (!is_null) begin
      upd.sum    = grp_rd_q.sum + add_val;
      upd.normal = 1'b1;
    end
  end

  // Group memory write port: clearing sweep, or write-back of an added row
  always_comb begin
    grp_we = 1'b0;
    grp_wa = grp_q;
    grp_wd = upd;
    if (state_q == ST_CLEAR) begin
      grp_we = 1'b1;
      grp_wa = clr_q;
      grp_wd = '0;
    end else if (state_q == ST_EXEC) begin
      grp_we = !is_null;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_we) begin
      grp_mem[grp_wa] <= grp_wd;
    end
    if (row_acc) begin
      grp_rd_q <= grp_mem[grp_ra];
    end
  end

  // Dictionary: loads write, rows read; never in the same cycle
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      dict_mem[dict_a] <= '{null_bit: item_i.row_null, value: item_i.row_value};
    end
    if (row_acc) begin
      dict_rd_q <= dict_mem[dict_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_acc) begin
      grp_q       <= grp_ra;
      grp_out_q   <= grp_red;
      row_value_q <= item_i.row_value;
      row_null_q  <= item_i.row_null;
      batch_q     <= item_i.batch_end;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_source_q   <= gisu_pkg::VS_ROW;
      null_source_q    <= gisu_pkg::NS_NEVER;
      constant_value_q <= '0;
      constant_null_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gisu_pkg::REG_VALUE_SOURCE:   value_source_q   <= cfg_data_i[1:0];
        gisu_pkg::REG_NULL_SOURCE:    null_source_q    <= cfg_data_i[1:0];
        gisu_pkg::REG_CONSTANT_VALUE: constant_value_q <= cfg_data_i;
        gisu_pkg::REG_CONSTANT_NULL:  constant_null_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      result_valid_o <= 1'b0;
      result_o       <= '0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == GW'(GROUP_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (row_acc) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q                <= ST_IDLE;
          result_valid_o         <= 1'b1;
          result_o.group_out     <= grp_out_q;
          result_o.group_sum     <= upd.sum;
          result_o.group_normal  <= upd.normal;
          result_o.row_added     <= !is_null;
          result_o.batch_done    <= batch_q;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/grouped_int64_sum_update_test.sv -----
module grouped_int64_sum_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GROUP_COUNT = 1024;
  localparam int unsigned DICT_DEPTH  = 1024;
  // Generous cycle budget: clearing sweep plus every item at the slowest sender.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Random items per register setting.
  localparam int unsigned ITEMS_PER_SETTING = 92;
  // Value source code with no meaning of its own; it must act like the row value.
  localparam logic [1:0] VS_UNUSED = 2'd3;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  gisu_pkg::item_t   item_i     = '0;
  logic              result_valid_o;
  gisu_pkg::result_t result_o;
  logic              cfg_we_i   = 1'b0;
  logic [1:0]        cfg_idx_i  = '0;
  logic [63:0]       cfg_data_i = '0;

  grouped_int64_sum_update #(
    .GROUP_COUNT(GROUP_COUNT),
    .DICT_DEPTH (DICT_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the aggregation state, updated at each accept edge.
  // ---------------------------------------------------------------------------
  logic [63:0] group_sum_q   [GROUP_COUNT];
  logic        group_normal_q[GROUP_COUNT];
  logic [63:0] dict_value_q  [DICT_DEPTH];
  logic        dict_null_q   [DICT_DEPTH];

  // Register mirror, updated whenever the testbench writes a register.
  logic [1:0]  value_src_q   = gisu_pkg::VS_ROW;
  logic [1:0]  null_src_q    = gisu_pkg::NS_NEVER;
  logic [63:0] const_value_q = '0;
  logic        const_null_q  = 1'b0;

  gisu_pkg::result_t expected_sums[$];   // group entries still to come back, oldest first
  gisu_pkg::item_t   pending_items[$];   // items waiting for the driver

  // Generator-side view of which dictionary entries hold data; rows only
  // ever point at these, since unwritten entries are undefined.
  bit          dict_loaded[DICT_DEPTH];
  int unsigned dict_written[$];

  int unsigned sender_idle_pct = 27;
  int unsigned error_count     = 0;
  int unsigned rows_checked    = 0;
  int unsigned loads_applied   = 0;
  int unsigned settings_run    = 0;
  int unsigned cycle_count     = 0;

  initial begin
    for (int i = 0; i < GROUP_COUNT; i++) begin
      group_sum_q[10'(i)]    = '0;
      group_normal_q[10'(i)] = 1'b0;
    end
    for (int i = 0; i < DICT_DEPTH; i++) begin
      dict_value_q[10'(i)] = '0;
      dict_null_q[10'(i)]  = 1'b0;
      dict_loaded[10'(i)]  = 1'b0;
    end
  end

  // Apply one accepted item to the shadow state; rows queue their expected entry.
  task automatic absorb_item(input gisu_pkg::item_t it);
    logic [9:0]        g;
    logic [9:0]        d;
    logic [63:0]       addend;
    logic              is_null;
    gisu_pkg::result_t r;
    g = 10'(it.group_index % GROUP_COUNT);
    d = 10'(it.dict_index % DICT_DEPTH);
    if (it.op == gisu_pkg::OP_LOAD) begin
      dict_value_q[d] = it.row_value;
      dict_null_q[d]  = it.row_null;
      loads_applied++;
    end else begin
      case (value_src_q)
        gisu_pkg::VS_CONST: addend = const_value_q;
        gisu_pkg::VS_DICT:  addend = dict_value_q[d];
        default:            addend = it.row_value;   // row value, and the unused code
      endcase
      case (null_src_q)
        gisu_pkg::NS_ROW:   is_null = it.row_null;
        gisu_pkg::NS_CONST: is_null = const_null_q;
        gisu_pkg::NS_DICT:  is_null = dict_null_q[d];
        default:            is_null = 1'b0;
      endcase
      if (!is_null) begin
        group_sum_q[g]    = group_sum_q[g] + addend;   // wraps mod 2^64
        group_normal_q[g] = 1'b1;
      end
      r.group_out    = g;
      r.group_sum    = group_sum_q[g];
      r.group_normal = group_normal_q[g];
      r.row_added    = !is_null;
      r.batch_done   = it.batch_end;
      expected_sums.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: holds start with an item until accepted, then may idle before the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    logic taken;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        absorb_item(item_i);
      end
      if (start && !taken) begin
        // item still waiting on busy: keep it up
      end else if (pending_items.size() > 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        item_i <= pending_items.pop_front();
        start  <= 1'b1;
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest expected entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    gisu_pkg::result_t want;
    logic              bad;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_sums.size() == 0) begin
        if (error_count < 10) begin
          $display("tb: unexpected result at cycle %0d: group %0d sum %0d",
                   cycle_count, result_o.group_out, result_o.group_sum);
        end
        error_count++;
      end else begin
        want = expected_sums.pop_front();
        rows_checked++;
        bad = (result_o.group_out    !== want.group_out)    ||
              (result_o.group_sum    !== want.group_sum)    ||
              (result_o.group_normal !== want.group_normal) ||
              (result_o.row_added    !== want.row_added)    ||
              (result_o.batch_done   !== want.batch_done);
        if (bad) begin
          if (error_count < 10) begin
            $display("tb: mismatch at cycle %0d (got/exp): group %0d/%0d sum %0d/%0d",
                     cycle_count, result_o.group_out, want.group_out,
                     result_o.group_sum, want.group_sum);
            $display("    normal %b/%b added %b/%b batch_done %b/%b",
                     result_o.group_normal, want.group_normal,
                     result_o.row_added, want.row_added,
                     result_o.batch_done, want.batch_done);
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic gisu_pkg::item_t mk(input logic op, input logic [9:0] grp,
                                         input logic [63:0] val, input logic nul,
                                         input logic [9:0] didx, input logic bend);
    gisu_pkg::item_t it;
    it.op          = op;
    it.group_index = grp;
    it.row_value   = val;
    it.row_null    = nul;
    it.dict_index  = didx;
    it.batch_end   = bend;
    return it;
  endfunction

  task automatic queue_item(input gisu_pkg::item_t it);
    if (it.op == gisu_pkg::OP_LOAD && !dict_loaded[it.dict_index]) begin
      dict_loaded[it.dict_index] = 1'b1;
      dict_written.push_back(32'(it.dict_index));
    end
    pending_items.push_back(it);
  endtask

  // Biased toward the values that stress the adder's wrap.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0:       return S64_MAX;
      1:       return S64_MIN;
      2:       return '1;
      3:       return '0;
      4:       return 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_random_item();
    logic [9:0] grp;
    if ($urandom_range(3) == 0) begin
      queue_item(mk(gisu_pkg::OP_LOAD, 10'($urandom), pick_value(), 1'($urandom),
                    10'($urandom), 1'($urandom)));
    end else begin
      // Half the rows hit a few hot groups so sums build up and wrap.
      case ($urandom_range(7))
        0:       grp = 10'd0;
        1:       grp = 10'd1;
        2:       grp = 10'd511;
        3:       grp = 10'd1023;
        default: grp = 10'($urandom);
      endcase
      queue_item(mk(gisu_pkg::OP_ROW, grp, pick_value(), 1'($urandom),
                    10'(dict_written[$urandom_range(dict_written.size() - 1)]),
                    $urandom_range(7) == 0));
    end
  endtask

  // Block is idle once the driver is empty, no result is outstanding and a
  // load's tail has had time to land.
  task automatic wait_idle();
    while (pending_items.size() != 0 || start || busy !== 1'b0 ||
           expected_sums.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      gisu_pkg::REG_VALUE_SOURCE:   value_src_q   = data[1:0];
      gisu_pkg::REG_NULL_SOURCE:    null_src_q    = data[1:0];
      gisu_pkg::REG_CONSTANT_VALUE: const_value_q = data;
      default:                      const_null_q  = data[0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One register setting followed by a burst of random items.
  task automatic run_setting(input logic [1:0] vs, input logic [1:0] ns,
                             input logic [63:0] cv, input logic cn,
                             input int unsigned idle_pct);
    wait_idle();
    write_reg(gisu_pkg::REG_VALUE_SOURCE,   {62'd0, vs});
    write_reg(gisu_pkg::REG_NULL_SOURCE,    {62'd0, ns});
    write_reg(gisu_pkg::REG_CONSTANT_VALUE, cv);
    write_reg(gisu_pkg::REG_CONSTANT_NULL,  {63'd0, cn});
    sender_idle_pct = idle_pct;
    settings_run++;
    repeat (ITEMS_PER_SETTING) queue_random_item();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: flat row value, never null. Loads come first so that
    // rows always point at written dictionary entries.
    sender_idle_pct = 27;
    settings_run    = 1;
    queue_item(mk(gisu_pkg::OP_LOAD, 10'd1023, S64_MAX, 1'b1, 10'd0,    1'b1));
    queue_item(mk(gisu_pkg::OP_LOAD, 10'd0,    S64_MIN, 1'b0, 10'd1023, 1'b0));
    queue_item(mk(gisu_pkg::OP_LOAD, 10'd5,    64'd42,  1'b0, 10'd512,  1'b1));
    queue_item(mk(gisu_pkg::OP_ROW,  10'd0,    S64_MAX, 1'b0, 10'd0,    1'b0));
    // max + 1 wraps to min; row_null is ignored in never-null mode
    queue_item(mk(gisu_pkg::OP_ROW,  10'd0,    64'd1,   1'b1, 10'd1023, 1'b1));
    queue_item(mk(gisu_pkg::OP_ROW,  10'd1023, S64_MIN, 1'b0, 10'd0,    1'b0));
    // min + (-1) wraps to max
    queue_item(mk(gisu_pkg::OP_ROW,  10'd1023, '1,      1'b0, 10'd512,  1'b1));
    // zero added still turns the group normal
    queue_item(mk(gisu_pkg::OP_ROW,  10'd7,    '0,      1'b0, 10'd0,    1'b0));

    // Unused value source code with row null flags.
    wait_idle();
    write_reg(gisu_pkg::REG_VALUE_SOURCE, {62'd0, VS_UNUSED});
    write_reg(gisu_pkg::REG_NULL_SOURCE,  {62'd0, gisu_pkg::NS_ROW});
    // null row on an empty group reports zero, empty, not added
    queue_item(mk(gisu_pkg::OP_ROW, 10'd9,    S64_MAX,   1'b1, 10'd0,    1'b0));
    queue_item(mk(gisu_pkg::OP_ROW, 10'd9,    -64'sd5,   1'b0, 10'd0,    1'b1));
    // null row on a normal group leaves the sum alone
    queue_item(mk(gisu_pkg::OP_ROW, 10'd0,    S64_MAX,   1'b1, 10'd1023, 1'b0));
    queue_item(mk(gisu_pkg::OP_ROW, 10'd1023, 64'd12345, 1'b0, 10'd512,  1'b1));

    // Random phases; sender idles 27%, then 71%, then never.
    run_setting(gisu_pkg::VS_CONST, gisu_pkg::NS_ROW,   S64_MAX,              1'b0, 27);
    run_setting(gisu_pkg::VS_DICT,  gisu_pkg::NS_DICT,  S64_MIN,              1'b1, 27);
    run_setting(VS_UNUSED,          gisu_pkg::NS_CONST, '1,                   1'b0, 27);
    run_setting(gisu_pkg::VS_CONST, gisu_pkg::NS_CONST, 64'd1,                1'b1, 71);
    run_setting(gisu_pkg::VS_DICT,  gisu_pkg::NS_ROW,   {$urandom, $urandom}, 1'b0, 71);
    run_setting(gisu_pkg::VS_ROW,   gisu_pkg::NS_DICT,  '0,                   1'b0, 71);
    run_setting(VS_UNUSED,          gisu_pkg::NS_NEVER, {$urandom, $urandom}, 1'b1, 0);
    run_setting(gisu_pkg::VS_DICT,  gisu_pkg::NS_NEVER, S64_MIN,              1'b0, 0);

    wait_idle();
    repeat (10) @(posedge clk_i);
    error_count += expected_sums.size();

    $display("tb: %0d row results checked, %0d dictionary loads, %0d register settings",
             rows_checked, loads_applied, settings_run);
    $display("tb: value sources row/const/dict/unused and all four null sources exercised");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d errors", error_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
